// File: src/nnis_pkg.sv
`default_nettype none
package nnis_pkg;

	localparam int COORD_W    = 8;
	localparam int DIM_W      = 9;
	localparam int DIM_MAX    = (1 << DIM_W) - 1;
	localparam int PIX_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int NUM_W      = 18;
	localparam int DIV_STAGES = 3;
	localparam int DIV_STEPS  = NUM_W / DIV_STAGES;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd3;

	localparam logic [DIM_W-1:0] RST_SOURCE_DIM = 9'd256;
	localparam logic [DIM_W-1:0] RST_TARGET_DIM = 9'd150;

	typedef struct packed {
		logic [DIM_W-1:0] rem;
		logic [NUM_W-1:0] nq;
	} div_t;

	typedef struct packed {
		logic               op;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic [PIX_W-1:0]   pixel;
	} item_t;

	typedef struct packed {
		logic [DIM_W-1:0] sw;
		logic [DIM_W-1:0] sh;
		logic [DIM_W-1:0] sw_m1;
		logic [DIM_W-1:0] sh_m1;
		logic [DIM_W-1:0] tw;
		logic [DIM_W-1:0] th;
	} dims_t;

endpackage
`default_nettype wire

// File: src/nnis_if.sv
`default_nettype none
interface nnis_req_if import nnis_pkg::*;;
	logic               valid;
	logic               ready;
	logic               op;
	logic [COORD_W-1:0] column;
	logic [COORD_W-1:0] row;
	logic [PIX_W-1:0]   pixel_in;

	modport source (output valid, op, column, row, pixel_in, input ready);
	modport sink (input valid, op, column, row, pixel_in, output ready);
endinterface

interface nnis_res_if import nnis_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;

	modport source (output valid, pixel_out, input ready);
	modport sink (input valid, pixel_out, output ready);
endinterface

interface nnis_cfg_if import nnis_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/nnis_cfg_regs.sv
`default_nettype none
module nnis_cfg_regs import nnis_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	nnis_cfg_if.sink  cfg,
	output dims_t     dims
);

	localparam logic [DIM_W-1:0] SW_CAP = DIM_W'((MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH);
	localparam logic [DIM_W-1:0] SH_CAP =
		DIM_W'((MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT);

	logic [DIM_W-1:0] src_w_q;
	logic [DIM_W-1:0] src_h_q;
	logic [DIM_W-1:0] tgt_w_q;
	logic [DIM_W-1:0] tgt_h_q;
	logic [DIM_W-1:0] sw1;
	logic [DIM_W-1:0] sh1;

	function automatic logic [DIM_W-1:0] at_least_one(input logic [DIM_W-1:0] v);
		return (v == '0) ? DIM_W'(1) : v;
	endfunction

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= RST_SOURCE_DIM;
			src_h_q <= RST_SOURCE_DIM;
			tgt_w_q <= RST_TARGET_DIM;
			tgt_h_q <= RST_TARGET_DIM;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SOURCE_WIDTH:  src_w_q <= cfg.data;
				REG_SOURCE_HEIGHT: src_h_q <= cfg.data;
				REG_TARGET_WIDTH:  tgt_w_q <= cfg.data;
				REG_TARGET_HEIGHT: tgt_h_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// zero acts as one, source sizes saturate at the store size
	assign sw1 = at_least_one(src_w_q);
	assign sh1 = at_least_one(src_h_q);

	always_comb begin
		dims.sw    = (sw1 > SW_CAP) ? SW_CAP : sw1;
		dims.sh    = (sh1 > SH_CAP) ? SH_CAP : sh1;
		dims.sw_m1 = DIM_W'(dims.sw - DIM_W'(1));
		dims.sh_m1 = DIM_W'(dims.sh - DIM_W'(1));
		dims.tw    = at_least_one(tgt_w_q);
		dims.th    = at_least_one(tgt_h_q);
	end

endmodule
`default_nettype wire

// File: src/nnis_div_stage.sv
`default_nettype none
module nnis_div_stage import nnis_pkg::*; #(
	parameter int STEPS = 6
) (
	input  div_t             din,
	input  logic [DIM_W-1:0] divisor,
	output div_t             dout
);

	logic [DIM_W:0]   t;
	logic [DIM_W-1:0] r;
	logic [NUM_W-1:0] nq;

	// restoring steps, quotient bits shift in as numerator bits shift out
	always_comb begin
		r  = din.rem;
		nq = din.nq;
		t  = '0;
		for (int i = 0; i < STEPS; i++) begin
			t = {r, nq[NUM_W-1]};
			if (t >= {1'b0, divisor}) begin
				r  = DIM_W'(t - {1'b0, divisor});
				nq = {nq[NUM_W-2:0], 1'b1};
			end else begin
				r  = t[DIM_W-1:0];
				nq = {nq[NUM_W-2:0], 1'b0};
			end
		end
		dout.rem = r;
		dout.nq  = nq;
	end

endmodule
`default_nettype wire

// File: src/nnis_frame_store.sv
`default_nettype none
module nnis_frame_store import nnis_pkg::*; #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic             rd_en,
	input  logic [AW-1:0]    addr,
	input  logic [PIX_W-1:0] wdata,
	output logic [PIX_W-1:0] rdata
);

	logic [PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

// File: src/nearest_neighbour_image_scaler_core.sv
// throughput: one word per cycle while result.ready is high; six register stages
// (multiply, three divider stages of six quotient bits each, clamp and address,
// frame store read or write)
// reset clears valid bits and loads config registers with defaults; frame store contents are not cleared
`default_nettype none
module nearest_neighbour_image_scaler_core import nnis_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	nnis_cfg_if.sink    cfg,
	nnis_req_if.sink    request,
	nnis_res_if.source  result
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	dims_t dims;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_s6;

	item_t item_s1, item_s2, item_s3, item_s4;
	div_t  dx_s1, dx_s2, dx_s3, dx_s4;
	div_t  dy_s1, dy_s2, dy_s3, dy_s4;
	div_t  dx_n2, dx_n3, dx_n4;
	div_t  dy_n2, dy_n3, dy_n4;

	logic [DIM_W-1:0] sx;
	logic [DIM_W-1:0] sy;
	logic [DIM_W-1:0] x_sel;
	logic [DIM_W-1:0] y_sel;
	logic             wr_ok;

	logic             op_s5;
	logic             we_s5;
	logic [AW-1:0]    addr_s5;
	logic [PIX_W-1:0] pix_s5;
	logic [PIX_W-1:0] pix_s6;

	nnis_cfg_regs #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.dims   (dims)
	);

	// each stage takes a word when empty or when the next stage moves
	assign ld_s6 = !v_s6 || result.ready;
	assign ld_s5 = !v_s5 || ld_s6;
	assign ld_s4 = !v_s4 || ld_s5;
	assign ld_s3 = !v_s3 || ld_s4;
	assign ld_s2 = !v_s2 || ld_s3;
	assign ld_s1 = !v_s1 || ld_s2;

	assign request.ready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= request.valid;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
			if (ld_s4) v_s4 <= v_s3;
			if (ld_s5) v_s5 <= v_s4;
			if (ld_s6) v_s6 <= v_s5 && (op_s5 == OP_READ);
		end
	end

	// stage 1: numerators
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			item_s1.op     <= request.op;
			item_s1.column <= request.column;
			item_s1.row    <= request.row;
			item_s1.pixel  <= request.pixel_in;
			dx_s1.rem      <= '0;
			dx_s1.nq       <= NUM_W'(request.column) * NUM_W'(dims.sw);
			dy_s1.rem      <= '0;
			dy_s1.nq       <= NUM_W'(request.row) * NUM_W'(dims.sh);
		end
	end

	// stages 2 to 4: quotient bits
	nnis_div_stage #(.STEPS(DIV_STEPS)) u_dx2 (.din(dx_s1), .divisor(dims.tw), .dout(dx_n2));
	nnis_div_stage #(.STEPS(DIV_STEPS)) u_dy2 (.din(dy_s1), .divisor(dims.th), .dout(dy_n2));
	nnis_div_stage #(.STEPS(DIV_STEPS)) u_dx3 (.din(dx_s2), .divisor(dims.tw), .dout(dx_n3));
	nnis_div_stage #(.STEPS(DIV_STEPS)) u_dy3 (.din(dy_s2), .divisor(dims.th), .dout(dy_n3));
	nnis_div_stage #(.STEPS(DIV_STEPS)) u_dx4 (.din(dx_s3), .divisor(dims.tw), .dout(dx_n4));
	nnis_div_stage #(.STEPS(DIV_STEPS)) u_dy4 (.din(dy_s3), .divisor(dims.th), .dout(dy_n4));

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			item_s2 <= item_s1;
			dx_s2   <= dx_n2;
			dy_s2   <= dy_n2;
		end
		if (ld_s3) begin
			item_s3 <= item_s2;
			dx_s3   <= dx_n3;
			dy_s3   <= dy_n3;
		end
		if (ld_s4) begin
			item_s4 <= item_s3;
			dx_s4   <= dx_n4;
			dy_s4   <= dy_n4;
		end
	end

	// stage 5: clamp to source bounds, form store address
	always_comb begin
		sx = (dx_s4.nq > NUM_W'(dims.sw_m1)) ? dims.sw_m1 : dx_s4.nq[DIM_W-1:0];
		sy = (dy_s4.nq > NUM_W'(dims.sh_m1)) ? dims.sh_m1 : dy_s4.nq[DIM_W-1:0];
		if (item_s4.op == OP_READ) begin
			x_sel = sx;
			y_sel = sy;
		end else begin
			x_sel = DIM_W'(item_s4.column);
			y_sel = DIM_W'(item_s4.row);
		end
		wr_ok = (item_s4.op == OP_WRITE) && (int'(item_s4.column) < MAX_WIDTH)
			&& (int'(item_s4.row) < MAX_HEIGHT);
	end

	always_ff @(posedge clk) begin
		if (ld_s5) begin
			op_s5   <= item_s4.op;
			we_s5   <= wr_ok;
			addr_s5 <= AW'(AW'(y_sel) * AW'(MAX_WIDTH) + AW'(x_sel));
			pix_s5  <= item_s4.pixel;
		end
	end

	// stage 6: frame store access
	nnis_frame_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.wr_en (ld_s6 && v_s5 && we_s5),
		.rd_en (ld_s6 && v_s5 && (op_s5 == OP_READ)),
		.addr  (addr_s5),
		.wdata (pix_s5),
		.rdata (pix_s6)
	);

	assign result.valid     = v_s6;
	assign result.pixel_out = pix_s6;

endmodule
`default_nettype wire
